// ----- src/fhp_pkg.sv -----
// Package for the frame header parser.
// Holds the shared constants, codes and word types used by the front, queue, back
// and top files.
`timescale 1ns / 1ps

package fhp_pkg;

  localparam int unsigned MAX_PLANES    = 4;
  localparam int unsigned HDR_FIXED_LEN = 36;
  localparam int unsigned QDEPTH        = 4;
  localparam int unsigned IN_TDATA_W    = 8;
  localparam int unsigned OUT_TDATA_W   = 80;
  localparam int unsigned CFG_DATA_W    = 32;

  typedef enum logic [0:0] {
    REG_MAGIC   = 1'b0,
    REG_VERSION = 1'b1
  } fhp_reg_e;

  typedef enum logic [1:0] {
    CLS_MAGIC,
    CLS_VERSION,
    CLS_SKIP,
    CLS_FIELD
  } fhp_cls_e;

  typedef enum logic [3:0] {
    FID_SLOT   = 4'd0,
    FID_WIDTH  = 4'd1,
    FID_HEIGHT = 4'd2,
    FID_FOURCC = 4'd3,
    FID_FRAME  = 4'd4,
    FID_MATRIX = 4'd5,
    FID_RANGE  = 4'd6,
    FID_SITING = 4'd7,
    FID_PLANES = 4'd8,
    FID_PITCH  = 4'd9,
    FID_OFFSET = 4'd10
  } fhp_fid_e;

  typedef enum logic [2:0] {
    ERR_OK      = 3'd0,
    ERR_SHORT   = 3'd1,
    ERR_MAGIC   = 3'd2,
    ERR_VERSION = 3'd3,
    ERR_PLANES  = 3'd4,
    ERR_TRUNC   = 3'd5
  } fhp_err_e;

  // One queue entry: the results caused by one byte.
  typedef struct packed {
    logic        field_v;
    fhp_fid_e    field_id;
    logic [1:0]  plane_index;
    logic [63:0] value;
    logic        status_v;
    fhp_err_e    error_code;
  } fhp_entry_t;

  // One output word.
  typedef struct packed {
    logic        kind;
    logic        last;
    fhp_fid_e    field_id;
    logic [1:0]  plane_index;
    logic [63:0] value;
    fhp_err_e    error_code;
  } fhp_word_t;

endpackage

// ----- src/frame_header_parser_unit.sv -----
// Top level of the frame header parser: front, result queue and back.
// Depends on fhp_pkg, fhp_front, fhp_queue and fhp_back.
//
// Takes one header byte per clock and never stalls the input while the result
// queue has room. Each byte gives at most one field word, except the final
// byte of a buffer when it also closes a field: that byte gives a field word
// and then a status word, so the single output register carries two words for
// it. A four-entry queue between the classifier and the output register
// absorbs these bursts and output back-pressure; input ready falls only when
// the queue is full. Configuration writes take effect on the next clock.
`timescale 1ns / 1ps

module frame_header_parser_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [fhp_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [7:0] data_byte
  input  logic [fhp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [3:0] field_id, [5:4] plane_index, [69:6] value, [72:70] error_code
  output logic [fhp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // [0] kind
  output logic                              m_axis_tuser,
  output logic                              m_axis_tlast
);
  import fhp_pkg::*;

  fhp_entry_t push_entry, head;
  logic       push, full, pop, head_valid;
  fhp_word_t  word;

  fhp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (fhp_reg_e'(cfg_idx_i)),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .full_i      (full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  fhp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  fhp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .word_o       (word)
  );

  assign m_axis_tdata = {7'd0, word.error_code, word.value, word.plane_index, word.field_id};
  assign m_axis_tuser = word.kind;
  assign m_axis_tlast = word.last;

endmodule

// ----- src/fhp_front.sv -----
// Front end of the frame header parser: config registers, byte position,
// field classification, accumulation and status. Depends on fhp_pkg.
`timescale 1ns / 1ps

module fhp_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  fhp_pkg::fhp_reg_e               cfg_idx_i,
  input  logic [fhp_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      in_byte_i,
  input  logic                            in_last_i,
  input  logic                            full_i,
  output logic                            push_o,
  output fhp_pkg::fhp_entry_t             entry_o
);
  import fhp_pkg::*;

  logic [31:0] magic_q;
  logic [15:0] version_q;
  logic [7:0]  pos_q, pos_d;
  logic [63:0] acc_q, acc_d;
  logic [7:0]  pt_q, pt_d;
  logic        magic_mm_q, magic_mm_d;
  logic        version_mm_q, version_mm_d;

  fhp_cls_e    cls;
  fhp_fid_e    fid;
  logic [2:0]  k;
  logic        done;
  logic [1:0]  plane;
  logic [7:0]  r;
  logic [5:0]  q;
  logic [7:0]  qoff;
  logic        in_planes;
  logic        accept;
  logic        emit;
  logic [8:0]  length;
  logic [8:0]  need;
  fhp_err_e    err;

  function automatic logic planes_ok(input logic [7:0] pt);
    planes_ok = (pt != 8'd0) && (pt <= 8'(MAX_PLANES));
  endfunction

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q   <= '0;
      version_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAGIC:   magic_q   <= cfg_wdata_i;
        REG_VERSION: version_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  assign r         = pos_q - 8'(HDR_FIXED_LEN);
  assign q         = r[7:2];
  assign qoff      = {2'b00, q} - pt_q;
  assign in_planes = planes_ok(pt_q) && ({3'b000, r} < {pt_q, 3'b000});

  always_comb begin
    cls   = CLS_SKIP;
    fid   = FID_SLOT;
    k     = 3'd0;
    done  = 1'b1;
    plane = 2'd0;
    if (pos_q < 8'd4) begin
      cls  = CLS_MAGIC;
      k    = {1'b0, pos_q[1:0]};
      done = (pos_q[1:0] == 2'd3);
    end else if (pos_q < 8'd6) begin
      cls  = CLS_VERSION;
      k    = {2'b00, pos_q[0]};
      done = pos_q[0];
    end else if (pos_q < 8'd8) begin
      cls = CLS_SKIP;
    end else if (pos_q < 8'd24) begin
      cls  = CLS_FIELD;
      fid  = fhp_fid_e'({1'b0, pos_q[4:2]} - 4'd2);
      k    = {1'b0, pos_q[1:0]};
      done = (pos_q[1:0] == 2'd3);
    end else if (pos_q < 8'd32) begin
      cls  = CLS_FIELD;
      fid  = FID_FRAME;
      k    = pos_q[2:0];
      done = (pos_q[2:0] == 3'd7);
    end else if (pos_q < 8'(HDR_FIXED_LEN)) begin
      cls = CLS_FIELD;
      fid = fhp_fid_e'(4'(FID_MATRIX) + {2'b00, pos_q[1:0]});
    end else if (in_planes) begin
      cls  = CLS_FIELD;
      k    = {1'b0, r[1:0]};
      done = (r[1:0] == 2'd3);
      if ({2'b00, q} < pt_q) begin
        fid   = FID_PITCH;
        plane = q[1:0];
      end else begin
        fid   = FID_OFFSET;
        plane = qoff[1:0];
      end
    end
  end

  always_comb begin
    if (k == 3'd0) begin
      acc_d = {56'd0, in_byte_i};
    end else begin
      acc_d = acc_q | ({56'd0, in_byte_i} << {k, 3'b000});
    end
  end

  always_comb begin
    magic_mm_d   = magic_mm_q;
    version_mm_d = version_mm_q;
    pt_d         = pt_q;
    emit         = 1'b0;
    if (done && (pos_q != 8'hff)) begin
      case (cls)
        CLS_MAGIC:   magic_mm_d   = (acc_d[31:0] != magic_q);
        CLS_VERSION: version_mm_d = (acc_d[15:0] != version_q);
        CLS_FIELD: begin
          if (fid == FID_PLANES) begin
            pt_d = in_byte_i;
          end
          emit = !magic_mm_q && !version_mm_q;
        end
        default: ;
      endcase
    end
  end

  // need is only compared when the plane count is in range
  assign length = {1'b0, pos_q} + 9'd1;
  assign need   = 9'(HDR_FIXED_LEN) + {pt_d[5:0], 3'b000};

  always_comb begin
    if (length < 9'(HDR_FIXED_LEN)) begin
      err = ERR_SHORT;
    end else if (magic_mm_d) begin
      err = ERR_MAGIC;
    end else if (version_mm_d) begin
      err = ERR_VERSION;
    end else if (!planes_ok(pt_d)) begin
      err = ERR_PLANES;
    end else if ((pos_q != 8'hff) && (length < need)) begin
      err = ERR_TRUNC;
    end else begin
      err = ERR_OK;
    end
  end

  always_comb begin
    entry_o.field_v     = emit;
    entry_o.field_id    = fid;
    entry_o.plane_index = plane;
    entry_o.value       = acc_d;
    entry_o.status_v    = in_last_i;
    entry_o.error_code  = err;
  end

  assign push_o = accept && (emit || in_last_i);

  assign pos_d = (pos_q == 8'hff) ? pos_q : pos_q + 8'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      pt_q         <= '0;
      magic_mm_q   <= 1'b0;
      version_mm_q <= 1'b0;
    end else if (accept) begin
      if (in_last_i) begin
        pos_q        <= '0;
        pt_q         <= '0;
        magic_mm_q   <= 1'b0;
        version_mm_q <= 1'b0;
      end else begin
        pos_q        <= pos_d;
        pt_q         <= pt_d;
        magic_mm_q   <= magic_mm_d;
        version_mm_q <= version_mm_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      acc_q <= acc_d;
    end
  end

`ifndef SYNTH
  a_magic_clear_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q < 8'd4) |-> !magic_mm_q)
    else $error("magic mismatch flagged before the magic word completed");
  a_planes_after_fixed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pt_q != 8'd0) |-> (pos_q > 8'(HDR_FIXED_LEN - 1)))
    else $error("plane count set before the fixed header ended");
  a_no_field_on_mismatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && entry_o.field_v) |-> (!magic_mm_q && !version_mm_q))
    else $error("field word queued after a header mismatch");
`endif

endmodule

// ----- src/fhp_queue.sv -----
// Small register queue between the parser front and back.
// Depends on fhp_pkg.
`timescale 1ns / 1ps

module fhp_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  fhp_pkg::fhp_entry_t  entry_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 head_valid_o,
  output fhp_pkg::fhp_entry_t  head_o
);
  import fhp_pkg::*;

  localparam int unsigned PTR_W = $clog2(QDEPTH);
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  fhp_entry_t         mem_q [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o       = (cnt_q == CNT_W'(QDEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ----- src/fhp_back.sv -----
// Back end of the frame header parser: splits each queue entry into field
// and status words behind one output register. Depends on fhp_pkg.
`timescale 1ns / 1ps

module fhp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 head_valid_i,
  input  fhp_pkg::fhp_entry_t  head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output fhp_pkg::fhp_word_t   word_o
);
  import fhp_pkg::*;

  fhp_word_t out_q, out_d;
  logic      out_valid_q, out_valid_d;
  logic      field_sent_q, field_sent_d;
  logic      load;

  assign load = !out_valid_q || out_ready_i;

  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    field_sent_d = field_sent_q;
    pop_o        = 1'b0;
    if (load) begin
      out_valid_d = head_valid_i;
      if (head_valid_i) begin
        if (head_i.field_v && !field_sent_q) begin
          out_d.kind        = 1'b0;
          out_d.last        = !head_i.status_v;
          out_d.field_id    = head_i.field_id;
          out_d.plane_index = head_i.plane_index;
          out_d.value       = head_i.value;
          out_d.error_code  = ERR_OK;
          field_sent_d      = head_i.status_v;
          pop_o             = !head_i.status_v;
        end else begin
          out_d.kind        = 1'b1;
          out_d.last        = 1'b1;
          out_d.field_id    = FID_SLOT;
          out_d.plane_index = 2'd0;
          out_d.value       = 64'd0;
          out_d.error_code  = head_i.error_code;
          field_sent_d      = 1'b0;
          pop_o             = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      field_sent_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      field_sent_q <= field_sent_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign word_o      = out_q;

`ifndef SYNTH
  a_split_keeps_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    field_sent_q |-> (head_valid_i && head_i.status_v))
    else $error("status entry left the queue before its status word was sent");
  a_split_word_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    field_sent_q |-> (out_valid_q && !out_q.kind && !out_q.last))
    else $error("split entry without its field word in the output register");
`endif

endmodule
